### src/jac_pkg.sv
package jac_pkg;

  localparam int unsigned MvW           = 12;
  localparam int unsigned CntW          = 4;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 12;
  localparam int unsigned RoundLimitDef = 10;
  localparam int unsigned BiasMv        = 80;

  localparam logic [MvW-1:0]  GroundedMvRst   = MvW'(40);
  localparam logic [MvW-1:0]  VideoMvRst      = MvW'(150);
  localparam logic [MvW-1:0]  HeadsetMvRst    = MvW'(1000);
  localparam logic [MvW-1:0]  EciLowMvRst     = MvW'(1950);
  localparam logic [MvW-1:0]  EciHighMvRst    = MvW'(2200);
  localparam logic [CntW-1:0] RepeatNeededRst = CntW'(5);

  typedef enum logic [2:0] {
    TYPE_UNKNOWN    = 3'd0,
    TYPE_HEADPHONES = 3'd1,
    TYPE_VIDEO      = 3'd2,
    TYPE_OPEN       = 3'd3,
    TYPE_HEADSET    = 3'd4
  } acc_type_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_REPEAT = 3'd1,
    ACT_OPEN   = 3'd2,
    ACT_PROBE  = 3'd3,
    ACT_FIRST  = 3'd4,
    ACT_CANCEL = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    OP_PLUG  = 2'd0,
    OP_ROUND = 2'd1,
    OP_PROBE = 2'd2
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AUTODETECT = 3'd0,
    REG_BIAS       = 3'd1,
    REG_GROUNDED   = 3'd2,
    REG_VIDEO      = 3'd3,
    REG_HEADSET    = 3'd4,
    REG_ECI_LOW    = 3'd5,
    REG_ECI_HIGH   = 3'd6,
    REG_REPEAT     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic           bias_correct;
    logic [MvW-1:0] grounded_mv;
    logic [MvW-1:0] video_mv;
    logic [MvW-1:0] headset_mv;
  } cls_cfg_t;

  typedef struct packed {
    acc_type_t accessory_type;
    logic      report_valid;
    logic      jack_headphone;
    logic      jack_microphone;
    logic      jack_avout;
    logic      jack_mechanical;
    action_t   next_action;
    logic      button_enable;
  } result_t;

endpackage

### src/jack_accessory_classifier_unit.sv
// An accepted input beat yields its result beat in the cycle after; one item
// per cycle while out_ready is high. Classify and vote logic sits between the
// input handshake and a single output register, which refills as it drains.
// Reset (rst, synchronous): configuration returns to its defaults, the vote
// state and plug level clear, and the output register empties.
module jack_accessory_classifier_unit #(
  parameter int unsigned ROUND_LIMIT = jac_pkg::RoundLimitDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jac_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [jac_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic                          plug_present,
  input  logic                          eci0_high,
  input  logic                          eci1_high,
  input  logic [jac_pkg::MvW-1:0]       voltage_mv,
  input  logic                          probe_aborted,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    accessory_type,
  output logic                          report_valid,
  output logic                          jack_headphone,
  output logic                          jack_microphone,
  output logic                          jack_avout,
  output logic                          jack_mechanical,
  output logic [2:0]                    next_action,
  output logic                          button_enable
);
  import jac_pkg::*;

  localparam logic [CntW-1:0] RoundLimit = CntW'(ROUND_LIMIT);
  localparam logic [CntW-1:0] CntMax     = '1;

  logic            autodetect_enable;
  cls_cfg_t        cls_cfg;
  logic [MvW-1:0]  eci_low_mv;
  logic [MvW-1:0]  eci_high_mv;
  logic [CntW-1:0] repeat_needed;

  logic            is_plugged,     is_plugged_next;
  acc_type_t       current_type,   current_type_next;
  acc_type_t       candidate_type, candidate_type_next;
  logic [CntW-1:0] repeat_count,   repeat_count_next;
  logic [CntW-1:0] round_total,    round_total_next;
  logic            button_on,      button_on_next;
  logic            probe_pending,  probe_pending_next;

  result_t         res, res_next;
  acc_type_t       round_type;
  acc_type_t       fin_type;
  logic            fin;
  logic [CntW-1:0] rep_inc;
  logic [CntW-1:0] rnd_inc;
  logic            accept;

  jac_classify u_classify (
    .cfg        (cls_cfg),
    .eci0_high  (eci0_high),
    .eci1_high  (eci1_high),
    .voltage_mv (voltage_mv),
    .acc_type   (round_type)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  assign rep_inc = (repeat_count == CntMax) ? repeat_count : repeat_count + CntW'(1);
  assign rnd_inc = (round_total == CntMax) ? round_total : round_total + CntW'(1);

  always_comb begin
    is_plugged_next     = is_plugged;
    current_type_next   = current_type;
    candidate_type_next = candidate_type;
    repeat_count_next   = repeat_count;
    round_total_next    = round_total;
    button_on_next      = button_on;
    probe_pending_next  = probe_pending;
    fin                 = 1'b0;
    fin_type            = TYPE_UNKNOWN;
    res_next            = '0;
    res_next.next_action = ACT_NONE;

    unique case (operation)
      OP_PLUG: begin
        if (autodetect_enable && plug_present != is_plugged) begin
          is_plugged_next     = plug_present;
          current_type_next   = TYPE_UNKNOWN;
          candidate_type_next = TYPE_UNKNOWN;
          repeat_count_next   = '0;
          round_total_next    = '0;
          button_on_next      = 1'b0;
          probe_pending_next  = 1'b0;
          if (plug_present) begin
            res_next.next_action = ACT_FIRST;
          end else begin
            res_next.next_action  = ACT_CANCEL;
            res_next.report_valid = 1'b1;
          end
        end
      end
      OP_ROUND: begin
        if (current_type == TYPE_OPEN && eci1_high) begin
          res_next.next_action = ACT_OPEN;
        end else begin
          probe_pending_next = 1'b0;
          current_type_next  = TYPE_UNKNOWN;
          if (is_plugged) begin
            if (round_type == candidate_type) begin
              repeat_count_next = rep_inc;
            end else begin
              repeat_count_next   = CntW'(1);
              candidate_type_next = round_type;
            end
            round_total_next = rnd_inc;
            if (rnd_inc >= RoundLimit
                || (repeat_count_next >= repeat_needed && round_type == TYPE_UNKNOWN)) begin
              probe_pending_next   = 1'b1;
              res_next.next_action = ACT_PROBE;
            end else if (repeat_count_next >= repeat_needed) begin
              fin      = 1'b1;
              fin_type = round_type;
            end else begin
              res_next.next_action = ACT_REPEAT;
            end
          end
        end
      end
      OP_PROBE: begin
        if (probe_pending) begin
          probe_pending_next = 1'b0;
          if (!probe_aborted && is_plugged) begin
            fin      = 1'b1;
            fin_type = (voltage_mv > eci_low_mv && voltage_mv < eci_high_mv)
                     ? TYPE_HEADSET : TYPE_UNKNOWN;
          end
        end
      end
      default: begin
      end
    endcase

    if (fin) begin
      current_type_next        = fin_type;
      candidate_type_next      = TYPE_UNKNOWN;
      repeat_count_next        = '0;
      round_total_next         = '0;
      res_next.report_valid    = 1'b1;
      res_next.jack_mechanical = 1'b1;
      unique case (fin_type)
        TYPE_HEADSET: begin
          res_next.jack_headphone  = 1'b1;
          res_next.jack_microphone = 1'b1;
          button_on_next           = 1'b1;
        end
        TYPE_HEADPHONES: res_next.jack_headphone = 1'b1;
        TYPE_VIDEO:      res_next.jack_avout     = 1'b1;
        TYPE_OPEN:       res_next.next_action    = ACT_OPEN;
        default: begin
        end
      endcase
    end

    res_next.accessory_type = current_type_next;
    res_next.button_enable  = button_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      autodetect_enable    <= 1'b1;
      cls_cfg.bias_correct <= 1'b0;
      cls_cfg.grounded_mv  <= GroundedMvRst;
      cls_cfg.video_mv     <= VideoMvRst;
      cls_cfg.headset_mv   <= HeadsetMvRst;
      eci_low_mv           <= EciLowMvRst;
      eci_high_mv          <= EciHighMvRst;
      repeat_needed        <= RepeatNeededRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_AUTODETECT: autodetect_enable    <= cfg_data[0];
        REG_BIAS:       cls_cfg.bias_correct <= cfg_data[0];
        REG_GROUNDED:   cls_cfg.grounded_mv  <= cfg_data[MvW-1:0];
        REG_VIDEO:      cls_cfg.video_mv     <= cfg_data[MvW-1:0];
        REG_HEADSET:    cls_cfg.headset_mv   <= cfg_data[MvW-1:0];
        REG_ECI_LOW:    eci_low_mv           <= cfg_data[MvW-1:0];
        REG_ECI_HIGH:   eci_high_mv          <= cfg_data[MvW-1:0];
        REG_REPEAT:     repeat_needed        <= cfg_data[CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_plugged     <= 1'b0;
      current_type   <= TYPE_UNKNOWN;
      candidate_type <= TYPE_UNKNOWN;
      repeat_count   <= '0;
      round_total    <= '0;
      button_on      <= 1'b0;
      probe_pending  <= 1'b0;
      out_valid      <= 1'b0;
    end else if (accept) begin
      is_plugged     <= is_plugged_next;
      current_type   <= current_type_next;
      candidate_type <= candidate_type_next;
      repeat_count   <= repeat_count_next;
      round_total    <= round_total_next;
      button_on      <= button_on_next;
      probe_pending  <= probe_pending_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign accessory_type  = res.accessory_type;
  assign report_valid    = res.report_valid;
  assign jack_headphone  = res.jack_headphone;
  assign jack_microphone = res.jack_microphone;
  assign jack_avout      = res.jack_avout;
  assign jack_mechanical = res.jack_mechanical;
  assign next_action     = res.next_action;
  assign button_enable   = res.button_enable;

endmodule

### src/jac_classify.sv
module jac_classify (
  input  jac_pkg::cls_cfg_t         cfg,
  input  logic                      eci0_high,
  input  logic                      eci1_high,
  input  logic [jac_pkg::MvW-1:0]   voltage_mv,
  output jac_pkg::acc_type_t        acc_type
);
  import jac_pkg::*;

  logic signed [MvW:0] corrected;
  logic signed [MvW:0] grounded_s;
  logic signed [MvW:0] video_s;

  assign corrected  = cfg.bias_correct
                    ? $signed({1'b0, voltage_mv}) - $signed((MvW+1)'(BiasMv))
                    : $signed({1'b0, voltage_mv});
  assign grounded_s = $signed({1'b0, cfg.grounded_mv});
  assign video_s    = $signed({1'b0, cfg.video_mv});

  always_comb begin
    if (eci0_high) begin
      if (eci1_high) begin
        acc_type = TYPE_OPEN;
      end else if (voltage_mv < cfg.headset_mv) begin
        acc_type = TYPE_HEADSET;
      end else begin
        acc_type = TYPE_UNKNOWN;
      end
    end else if (corrected < grounded_s) begin
      acc_type = TYPE_HEADPHONES;
    end else if (corrected < video_s) begin
      acc_type = TYPE_VIDEO;
    end else begin
      acc_type = TYPE_UNKNOWN;
    end
  end

endmodule
